FILE: rtl/wgs_pkg.sv
// wgs_pkg: shared types and constants of the wave grid stencil step
// (item record, register indexes, damping and stability constants)
// no dependencies
package wgs_pkg;

    localparam int HGT_W      = 16;
    localparam int CFG_SIZE_W = 11;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int MIN_SIZE   = 3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_COLUMNS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_A_COEF  = 2'd2;

    // a above one half (Q0.16) makes the scheme unstable
    localparam logic [CFG_DATA_W-1:0] A_STABLE_MAX = 16'd32768;

    // depth damping, ground in Q3.12, factor in Q1.16
    localparam logic signed [HGT_W-1:0] GND_DRY   = 16'sd1225;
    localparam logic signed [HGT_W-1:0] GND_DEEP  = -16'sd1229;
    localparam logic [16:0]             DAMP_NONE = 17'd0;
    localparam logic [16:0]             DAMP_FULL = 17'd65536;

    typedef logic signed [HGT_W-1:0] height_t;

    typedef struct packed {
        height_t cur;
        height_t prv;
        height_t gnd;
        logic    same_half;
        logic    emit;
        logic    interior;
        logic    last;
        logic    unstable;
    } wgs_item_t;

endpackage

FILE: rtl/wave_grid_stencil_step.sv
// wave_grid_stencil_step: top level, configuration registers and wiring
// depends on wgs_pkg, wgs_front, wgs_queue, wgs_back
//
//  channel  dir  handshake            payload
//  s_       in   s_valid / s_ready    s_current_height, s_previous_height, s_ground_height
//  m_       out  m_valid / m_ready    m_new_height, m_unstable, m_last
//  cfg_     in   cfg_wr_en            cfg_index (0 columns, 1 rows, 2 a_coef), cfg_data
//
// the back end handles one point at a time: every point passes the line-store
// read and write steps; a first-row point ends there, a border or unstable point goes
// on to the output step, an interior point (four height reads) to the multiply/round chain
// a two-entry queue takes points while the back end works; s_ready drops only when full
// a stall on m_ready holds the back end in its output step
// reset clears counters, queue, output valid and registers (3, 3, 0); line stores keep content
module wave_grid_stencil_step #(
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 1024
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  wgs_pkg::height_t               s_current_height,
    input  wgs_pkg::height_t               s_previous_height,
    input  wgs_pkg::height_t               s_ground_height,
    output logic                           m_valid,
    input  logic                           m_ready,
    output wgs_pkg::height_t               m_new_height,
    output logic                           m_unstable,
    output logic                           m_last,
    input  logic                           cfg_wr_en,
    input  logic [wgs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [wgs_pkg::CFG_DATA_W-1:0] cfg_data
);
    import wgs_pkg::*;

    localparam int CW = $clog2(MAX_COLS);
    localparam int DW = $bits(wgs_item_t) + CW;

    logic [CFG_SIZE_W-1:0] columns_reg, rows_reg;
    logic [CFG_DATA_W-1:0] a_coef_reg;

    wgs_item_t     f_item, b_item;
    logic [CW-1:0] f_col, b_col;
    logic          f_valid, f_ready, b_valid, b_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            columns_reg <= CFG_SIZE_W'(MIN_SIZE);
            rows_reg    <= CFG_SIZE_W'(MIN_SIZE);
            a_coef_reg  <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_COLUMNS: columns_reg <= cfg_data[CFG_SIZE_W-1:0];
                REG_ROWS:    rows_reg    <= cfg_data[CFG_SIZE_W-1:0];
                REG_A_COEF:  a_coef_reg  <= cfg_data;
                default:     ;
            endcase
        end
    end

    wgs_front #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_front (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_current_height  (s_current_height),
        .s_previous_height (s_previous_height),
        .s_ground_height   (s_ground_height),
        .cfg_columns       (columns_reg),
        .cfg_rows          (rows_reg),
        .cfg_a_coef        (a_coef_reg),
        .q_valid           (f_valid),
        .q_ready           (f_ready),
        .q_item            (f_item),
        .q_col             (f_col)
    );

    wgs_queue #(
        .DW (DW)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   ({f_col, f_item}),
        .out_valid (b_valid),
        .out_ready (b_ready),
        .out_data  ({b_col, b_item})
    );

    wgs_back #(
        .MAX_COLS (MAX_COLS)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_a_coef   (a_coef_reg),
        .q_valid      (b_valid),
        .q_ready      (b_ready),
        .q_item       (b_item),
        .q_col        (b_col),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_new_height (m_new_height),
        .m_unstable   (m_unstable),
        .m_last       (m_last)
    );

endmodule

FILE: rtl/wgs_front.sv
// wgs_front: raster position counters and per-point classification
// depends on wgs_pkg
module wgs_front #(
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 1024
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  wgs_pkg::height_t                  s_current_height,
    input  wgs_pkg::height_t                  s_previous_height,
    input  wgs_pkg::height_t                  s_ground_height,
    input  logic [wgs_pkg::CFG_SIZE_W-1:0]    cfg_columns,
    input  logic [wgs_pkg::CFG_SIZE_W-1:0]    cfg_rows,
    input  logic [wgs_pkg::CFG_DATA_W-1:0]    cfg_a_coef,
    output logic                              q_valid,
    input  logic                              q_ready,
    output wgs_pkg::wgs_item_t                q_item,
    output logic [$clog2(MAX_COLS)-1:0]       q_col
);
    import wgs_pkg::*;

    localparam int CW    = $clog2(MAX_COLS);
    localparam int RW    = $clog2(MAX_ROWS);
    localparam int CSZ_W = ($clog2(MAX_COLS + 1) > CFG_SIZE_W) ? $clog2(MAX_COLS + 1)
                                                                : CFG_SIZE_W;
    localparam int RSZ_W = ($clog2(MAX_ROWS + 1) > CFG_SIZE_W) ? $clog2(MAX_ROWS + 1)
                                                                : CFG_SIZE_W;

    logic [CW-1:0]    col_reg, col_next;
    logic [RW-1:0]    row_reg, row_next;
    logic [CSZ_W-1:0] cols_raw, cols_lim, col_inc;
    logic [RSZ_W-1:0] rows_raw, rows_lim, row_ext, row_inc;
    logic             col_end;
    logic             accept;

    assign accept  = s_valid && q_ready;
    assign s_ready = q_ready;
    assign q_valid = s_valid;
    assign q_col   = col_reg;

    // sizes in use are clamped to [3, max]
    always_comb begin
        cols_raw = CSZ_W'(cfg_columns);
        rows_raw = RSZ_W'(cfg_rows);
        priority if (cols_raw < CSZ_W'(MIN_SIZE)) begin
            cols_lim = CSZ_W'(MIN_SIZE);
        end else if (cols_raw > CSZ_W'(MAX_COLS)) begin
            cols_lim = CSZ_W'(MAX_COLS);
        end else begin
            cols_lim = cols_raw;
        end
        priority if (rows_raw < RSZ_W'(MIN_SIZE)) begin
            rows_lim = RSZ_W'(MIN_SIZE);
        end else if (rows_raw > RSZ_W'(MAX_ROWS)) begin
            rows_lim = RSZ_W'(MAX_ROWS);
        end else begin
            rows_lim = rows_raw;
        end
    end

    always_comb begin
        col_inc = CSZ_W'(col_reg) + CSZ_W'(1);
        row_ext = RSZ_W'(row_reg);
        row_inc = row_ext + RSZ_W'(1);
        col_end = col_inc >= cols_lim;

        q_item.cur       = s_current_height;
        q_item.prv       = s_previous_height;
        q_item.gnd       = s_ground_height;
        q_item.same_half = row_reg[0];
        q_item.emit      = row_reg != '0;
        // the emitted point is one row behind the incoming one
        q_item.interior  = (row_ext >= RSZ_W'(2)) && (row_ext < rows_lim) &&
                           (col_reg != '0) && (col_inc < cols_lim);
        q_item.last      = (row_inc == rows_lim) && (col_inc == cols_lim);
        q_item.unstable  = cfg_a_coef > A_STABLE_MAX;

        col_next = col_reg;
        row_next = row_reg;
        if (accept) begin
            if (col_end) begin
                col_next = '0;
                row_next = (row_inc >= rows_lim) ? '0 : row_inc[RW-1:0];
            end else begin
                col_next = col_inc[CW-1:0];
                // rows shrunk under the counter
                if (row_ext >= rows_lim) begin
                    row_next = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

FILE: rtl/wgs_queue.sv
// wgs_queue: two-entry queue between the classifying front and the back end
// depends on wgs_pkg only through the width given by its user
module wgs_queue #(
    parameter int DW = 8
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [DW-1:0] in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [DW-1:0] out_data
);
    localparam int DEPTH = 2;
    localparam int AW    = $clog2(DEPTH);
    localparam int NW    = $clog2(DEPTH + 1);

    logic [DW-1:0] slot_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [NW-1:0] count_reg, count_next;
    logic          push, pop;

    assign in_ready  = count_reg != NW'(DEPTH);
    assign out_valid = count_reg != '0;
    assign out_data  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + NW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - NW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + AW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

FILE: rtl/wgs_back.sv
// wgs_back: line stores, stencil arithmetic sequencer and result register
// depends on wgs_pkg
module wgs_back #(
    parameter int MAX_COLS = 1024
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [wgs_pkg::CFG_DATA_W-1:0] cfg_a_coef,
    input  logic                           q_valid,
    output logic                           q_ready,
    input  wgs_pkg::wgs_item_t             q_item,
    input  logic [$clog2(MAX_COLS)-1:0]    q_col,
    output logic                           m_valid,
    input  logic                           m_ready,
    output wgs_pkg::height_t               m_new_height,
    output logic                           m_unstable,
    output logic                           m_last
);
    import wgs_pkg::*;

    localparam int CW     = $clog2(MAX_COLS);
    localparam int HDEPTH = 2 * MAX_COLS;
    localparam int HAW    = $clog2(HDEPTH);

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_RD_CUR   = 4'd1;
    localparam logic [3:0] ST_RD_LEFT  = 4'd2;
    localparam logic [3:0] ST_RD_RIGHT = 4'd3;
    localparam logic [3:0] ST_RD_UP    = 4'd4;
    localparam logic [3:0] ST_WRITE    = 4'd5;
    localparam logic [3:0] ST_MUL      = 4'd6;
    localparam logic [3:0] ST_ACC      = 4'd7;
    localparam logic [3:0] ST_PP       = 4'd8;
    localparam logic [3:0] ST_SUM      = 4'd9;
    localparam logic [3:0] ST_OUT      = 4'd10;

    // line stores
    height_t height_mem [HDEPTH];
    height_t prev_mem   [MAX_COLS];
    height_t gnd_mem    [MAX_COLS];

    logic [3:0]     state_reg, state_next;
    wgs_item_t      item_reg;
    logic [CW-1:0]  col_reg;

    logic [HAW-1:0] other_base, same_base, col_addr, h_rd_addr, h_wr_addr;
    logic           h_rd_en, pg_rd_en, wr_en;
    height_t        h_rd_data_reg, prev_rd_reg, gnd_rd_reg;

    height_t        cur_reg, prv_reg, gnd_reg, left_reg, right_reg, up_reg;

    logic signed [17:0] sum4;
    logic signed [16:0] a_s;
    logic signed [18:0] b_coef;
    logic signed [34:0] prod_a, prod_b;
    logic signed [32:0] gmul;
    logic signed [34:0] prod_a_reg, prod_b_reg;
    logic signed [32:0] gmul_reg;

    logic signed [37:0] acc, acc_reg;
    logic signed [32:0] g_round;
    logic signed [21:0] d_mid;
    logic [16:0]        damp, damp_reg;

    logic signed [36:0] pp_hi, pp_hi_reg;
    logic [35:0]        pp_lo, pp_lo_reg;

    logic signed [57:0] total;
    logic signed [25:0] r_q12;
    height_t            sat, res_reg;

    logic               out_free, load_out;
    logic               m_valid_reg;
    height_t            m_new_height_reg;
    logic               m_unstable_reg, m_last_reg;

    assign q_ready  = state_reg == ST_IDLE;
    assign out_free = !m_valid_reg || m_ready;
    assign load_out = (state_reg == ST_OUT) && out_free;

    // ---------------- sequencer ----------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (q_valid) begin
                state_next = ST_RD_CUR;
            end
            ST_RD_CUR:   state_next = ST_RD_LEFT;
            ST_RD_LEFT:  state_next = ST_RD_RIGHT;
            ST_RD_RIGHT: state_next = ST_RD_UP;
            ST_RD_UP:    state_next = ST_WRITE;
            ST_WRITE: begin
                priority if (!item_reg.emit) begin
                    state_next = ST_IDLE;
                end else if (item_reg.unstable || !item_reg.interior) begin
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:      state_next = ST_ACC;
            ST_ACC:      state_next = ST_PP;
            ST_PP:       state_next = ST_SUM;
            ST_SUM:      state_next = ST_OUT;
            ST_OUT:      if (out_free) begin
                state_next = ST_IDLE;
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // ---------------- line store access ----------------
    always_comb begin
        other_base = item_reg.same_half ? '0 : HAW'(MAX_COLS);
        same_base  = item_reg.same_half ? HAW'(MAX_COLS) : '0;
        col_addr   = HAW'(col_reg);
        h_wr_addr  = same_base + col_addr;
        pg_rd_en   = state_reg == ST_RD_CUR;
        wr_en      = state_reg == ST_WRITE;
        h_rd_en    = 1'b0;
        h_rd_addr  = other_base + col_addr;
        unique case (state_reg)
            ST_RD_CUR: begin
                h_rd_en = 1'b1;
            end
            // neighbours exist only for interior points
            ST_RD_LEFT: begin
                h_rd_en   = item_reg.interior;
                h_rd_addr = other_base + col_addr - HAW'(1);
            end
            ST_RD_RIGHT: begin
                h_rd_en   = item_reg.interior;
                h_rd_addr = other_base + col_addr + HAW'(1);
            end
            ST_RD_UP: begin
                h_rd_en   = 1'b1;
                h_rd_addr = same_base + col_addr;
            end
            default: begin
                h_rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (h_rd_en) begin
            h_rd_data_reg <= height_mem[h_rd_addr];
        end
        if (pg_rd_en) begin
            prev_rd_reg <= prev_mem[col_reg];
            gnd_rd_reg  <= gnd_mem[col_reg];
        end
        if (wr_en) begin
            height_mem[h_wr_addr] <= item_reg.cur;
            prev_mem[col_reg]     <= item_reg.prv;
            gnd_mem[col_reg]      <= item_reg.gnd;
        end
    end

    // ---------------- arithmetic ----------------
    always_comb begin
        sum4   = 18'(up_reg) + 18'(item_reg.cur) + 18'(left_reg) + 18'(right_reg);
        a_s    = $signed({1'b0, cfg_a_coef});
        b_coef = 19'sd131072 - $signed({1'b0, cfg_a_coef, 2'b00});
        prod_a = a_s * sum4;
        prod_b = b_coef * cur_reg;
        gmul   = 17'sd39322 * gnd_reg;

        acc = 38'(prod_a_reg) + 38'(prod_b_reg) - (38'(prv_reg) <<< 16);

        // 0.5 - 0.6 * ground, rounded, between the two depth limits
        g_round = gmul_reg + 33'sd2048;
        d_mid   = 22'sd32768 - 22'($signed(g_round[32:12]));
        priority if (gnd_reg >= GND_DRY) begin
            damp = DAMP_NONE;
        end else if (gnd_reg <= GND_DEEP) begin
            damp = DAMP_FULL;
        end else begin
            damp = d_mid[16:0];
        end

        // acc * damp in two partial products
        pp_hi = $signed(acc_reg[37:19]) * $signed({1'b0, damp_reg});
        pp_lo = acc_reg[18:0] * damp_reg;

        total = (58'(pp_hi_reg) <<< 19) + $signed(58'(pp_lo_reg)) + 58'sd2147483648;
        r_q12 = $signed(total[57:32]);
        priority if (r_q12 > 26'sd32767) begin
            sat = 16'sh7fff;
        end else if (r_q12 < -26'sd32768) begin
            sat = 16'sh8000;
        end else begin
            sat = r_q12[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && q_valid) begin
            item_reg <= q_item;
            col_reg  <= q_col;
        end
        if (state_reg == ST_RD_LEFT) begin
            cur_reg <= h_rd_data_reg;
            prv_reg <= prev_rd_reg;
            gnd_reg <= gnd_rd_reg;
        end
        if (state_reg == ST_RD_RIGHT) begin
            left_reg <= h_rd_data_reg;
        end
        if (state_reg == ST_RD_UP) begin
            right_reg <= h_rd_data_reg;
        end
        if (state_reg == ST_WRITE) begin
            up_reg <= h_rd_data_reg;
        end
        if (state_reg == ST_MUL) begin
            prod_a_reg <= prod_a;
            prod_b_reg <= prod_b;
            gmul_reg   <= gmul;
        end
        if (state_reg == ST_ACC) begin
            acc_reg  <= acc;
            damp_reg <= damp;
        end
        if (state_reg == ST_PP) begin
            pp_hi_reg <= pp_hi;
            pp_lo_reg <= pp_lo;
        end
        if (state_reg == ST_SUM) begin
            res_reg <= sat;
        end
        if (load_out) begin
            priority if (item_reg.unstable) begin
                m_new_height_reg <= cur_reg;
            end else if (!item_reg.interior) begin
                m_new_height_reg <= prv_reg;
            end else begin
                m_new_height_reg <= res_reg;
            end
            m_unstable_reg <= item_reg.unstable;
            m_last_reg     <= item_reg.last;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_new_height = m_new_height_reg;
    assign m_unstable   = m_unstable_reg;
    assign m_last       = m_last_reg;

endmodule

FILE: rtl/wgs_checker.sv
// wgs_checker: port-level checks of the wave grid stencil step
// depends on wgs_pkg; bound to wave_grid_stencil_step below
module wgs_checker (
    input logic             aclk,
    input logic             aresetn,
    input logic             s_ready,
    input logic             m_valid,
    input logic             m_ready,
    input wgs_pkg::height_t m_new_height,
    input logic             m_unstable,
    input logic             m_last
);
    import wgs_pkg::*;

    // a stalled result holds until its transfer
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_new_height) &&
                                $stable(m_unstable) && $stable(m_last))
        else $error("result changed while stalled");

    // reset drops any pending result
    a_rst_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // queue is empty after reset so input is taken at once
    a_rst_in: assert property (@(posedge aclk)
        !aresetn |=> s_ready)
        else $error("input not ready right after reset");

endmodule

bind wave_grid_stencil_step wgs_checker u_wgs_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_new_height (m_new_height),
    .m_unstable   (m_unstable),
    .m_last       (m_last)
);

FILE: verif/wave_grid_stencil_step_test.sv
// wave_grid_stencil_step_test: self-checking bench for the wave grid stencil step
// streams grid points, predicts each new height in-bench and compares every m_ transfer
// depends on wgs_pkg and wave_grid_stencil_step
`timescale 1ns / 100ps

module wave_grid_stencil_step_test;
    import wgs_pkg::*;

    localparam int MAX_COLS      = 1024;
    localparam int MAX_ROWS      = 1024;
    localparam int RANDOM_ITEMS  = 200;
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT   = 800000;

    typedef struct packed {
        height_t new_height;
        logic    unstable;
        logic    last;
    } wave_result_t;

    logic                  aclk;
    logic                  aresetn           = 1'b0;
    logic                  s_valid           = 1'b0;
    logic                  s_ready;
    height_t               s_current_height  = '0;
    height_t               s_previous_height = '0;
    height_t               s_ground_height   = '0;
    logic                  m_valid;
    logic                  m_ready           = 1'b0;
    height_t               m_new_height;
    logic                  m_unstable;
    logic                  m_last;
    logic                  cfg_wr_en         = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index         = '0;
    logic [CFG_DATA_W-1:0] cfg_data          = '0;

    // grid state as the block should hold it
    height_t          height_rows [0:2*MAX_COLS-1];
    height_t          prev_row    [0:MAX_COLS-1];
    height_t          ground_row  [0:MAX_COLS-1];
    int unsigned      col_count   = 0;
    int unsigned      row_count   = 0;
    logic [10:0]      columns_reg = 11'd3;
    logic [10:0]      rows_reg    = 11'd3;
    logic [15:0]      a_coef_reg  = 16'd0;

    wave_result_t     pending_heights [$];
    wave_result_t     head_result;
    int unsigned      mismatch_count = 0;
    int unsigned      sent_count     = 0;
    int unsigned      burst_left     = 0;
    int unsigned      cycle_count    = 0;
    bit               sender_gaps    = 1'b1;

    wave_grid_stencil_step #(
        .MAX_COLS(MAX_COLS),
        .MAX_ROWS(MAX_ROWS)
    ) u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_current_height (s_current_height),
        .s_previous_height(s_previous_height),
        .s_ground_height  (s_ground_height),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_new_height     (m_new_height),
        .m_unstable       (m_unstable),
        .m_last           (m_last),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic int unsigned clamp_size(logic [10:0] v);
        if (v < 11'd3) return 3;
        if (v > MAX_COLS) return MAX_COLS;
        return v;
    endfunction

    // Q1.16 factor from the ground height under the point
    function automatic longint depth_damping(height_t g);
        longint gl;
        gl = g;
        if (g >= GND_DRY) return longint'(DAMP_NONE);
        if (g <= GND_DEEP) return longint'(DAMP_FULL);
        return 32768 - ((longint'(39322) * gl + 2048) >>> 12);
    endfunction

    // advance the grid by one accepted point, queueing the height it yields
    function automatic void step_wave_point(height_t cur_in, height_t prv_in, height_t gnd_in);
        int unsigned  cols, nrows, col, row, same, other, pr;
        longint       up, left, right, cur, prv, a, sum4, b, acc, r;
        bit           interior;
        wave_result_t res;
        cols  = clamp_size(columns_reg);
        nrows = clamp_size(rows_reg);
        col   = col_count % MAX_COLS;
        row   = row_count;
        same  = (row & 1) * MAX_COLS;
        other = ((row + 1) & 1) * MAX_COLS;
        if (row >= 1) begin
            pr           = row - 1;
            cur          = height_rows[other + col];
            prv          = prev_row[col];
            res.unstable = a_coef_reg > A_STABLE_MAX;
            interior     = pr >= 1 && pr + 1 < nrows && col >= 1 && col + 1 < cols;
            if (res.unstable) begin
                res.new_height = cur[15:0];
            end else if (!interior) begin
                res.new_height = prv[15:0];
            end else begin
                up    = height_rows[same + col];
                left  = height_rows[other + col - 1];
                right = height_rows[other + col + 1];
                a     = a_coef_reg;
                sum4  = up + longint'(cur_in) + left + right;
                b     = 131072 - 4 * a;
                acc   = a * sum4 + b * cur - prv * 65536;
                r     = (acc * depth_damping(ground_row[col]) + (longint'(1) << 31)) >>> 32;
                if (r > 32767) r = 32767;
                else if (r < -32768) r = -32768;
                res.new_height = r[15:0];
            end
            res.last = (row + 1 == nrows) && (col + 1 == cols);
            pending_heights.push_back(res);
        end
        height_rows[same + col] = cur_in;
        prev_row[col]           = prv_in;
        ground_row[col]         = gnd_in;
        if (col + 1 >= cols) begin
            col_count = 0;
            row_count = (row + 1 >= nrows) ? 0 : row + 1;
        end else begin
            col_count = col + 1;
            if (row >= nrows) row_count = 0;
        end
    endfunction

    function automatic height_t ground_edge(int unsigned i);
        case (i)
            0: return 16'sh8000;
            1: return 16'sd1224;
            2: return GND_DRY;
            3: return -16'sd1228;
            4: return GND_DEEP;
            5: return 16'sh7fff;
            6: return -16'sd1230;
            default: return 16'sd0;
        endcase
    endfunction

    function automatic height_t rand_height();
        case ($urandom_range(0, 7))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2, 3: return height_t'($urandom_range(0, 4095) - 2048);
            default: return height_t'($urandom);
        endcase
    endfunction

    function automatic height_t rand_ground();
        case ($urandom_range(0, 5))
            0: return ground_edge($urandom_range(0, 7));
            1: return height_t'($urandom);
            default: return height_t'($urandom_range(0, 2452) - 1228);
        endcase
    endfunction

    function automatic logic [15:0] pick_size();
        case ($urandom_range(0, 9))
            0: return 16'($urandom_range(0, 2));
            1: return 16'h0800;  // only bit 11 set, reads as zero
            2: return 16'($urandom_range(11, 40));
            default: return 16'($urandom_range(3, 10));
        endcase
    endfunction

    function automatic logic [15:0] pick_coef();
        case ($urandom_range(0, 9))
            0: return 16'd0;
            1: return A_STABLE_MAX;
            2: return A_STABLE_MAX + 16'd1;
            3: return 16'($urandom_range(32769, 65535));
            4: return 16'hffff;
            default: return 16'($urandom_range(0, 32768));
        endcase
    endfunction

    // called at a clock edge; returns at the edge of the transfer with valid still high
    task automatic send_point(height_t cur, height_t prv, height_t gnd);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (sender_gaps) begin
                gap     = $urandom_range(1, 10);
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid           <= 1'b1;
        s_current_height  <= cur;
        s_previous_height <= prv;
        s_ground_height   <= gnd;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        step_wave_point(cur, prv, gnd);
        sent_count++;
    endtask

    task automatic send_random_point();
        send_point(rand_height(), rand_height(), rand_ground());
    endtask

    task automatic finish_frame();
        while (col_count != 0 || row_count != 0) send_random_point();
    endtask

    // hold off the sender until every height is back and the block has drained
    task automatic wait_idle();
        s_valid    <= 1'b0;
        burst_left = 0;
        while (pending_heights.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_COLUMNS: columns_reg = value[10:0];
            REG_ROWS:    rows_reg    = value[10:0];
            REG_A_COEF:  a_coef_reg  = value;
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // 6x3 frame at reset rows and a = 0, interior grounds on the damping thresholds
    task automatic test_damping_edges();
        height_t cur, prv;
        write_reg(REG_COLUMNS, 16'd6);
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 6; c++) begin
                cur = height_t'(r * 5000 - c * 3000);
                prv = height_t'(c * 2500 - r * 4000);
                // full-scale swings to drive the result into both rails
                if (r == 1 && c == 3) begin
                    cur = 16'sh8000;
                    prv = 16'sh7fff;
                end
                if (r == 1 && c == 4) begin
                    cur = 16'sh7fff;
                    prv = 16'sh8000;
                end
                send_point(cur, prv, ground_edge(c));
            end
        end
    endtask

    // sizes below the minimum clamp to 3, coefficient just over one half
    task automatic test_unstable_clamped();
        wait_idle();
        write_reg(REG_COLUMNS, 16'd0);
        write_reg(REG_ROWS, 16'd1);
        write_reg(REG_A_COEF, A_STABLE_MAX + 16'd1);
        repeat (9) send_random_point();
    endtask

    // widest row, then narrowing while the column count is past the new bound
    task automatic test_wide_columns();
        wait_idle();
        write_reg(REG_COLUMNS, 16'hffff);
        write_reg(REG_A_COEF, 16'($urandom_range(0, 32768)));
        repeat (MAX_COLS + 8) send_random_point();
        wait_idle();
        write_reg(REG_COLUMNS, 16'd5);
        finish_frame();
    endtask

    // tallest frame cut short mid-row, so the row count wraps early
    task automatic test_tall_rows();
        wait_idle();
        write_reg(REG_COLUMNS, 16'd3);
        write_reg(REG_ROWS, 16'(MAX_ROWS));
        write_reg(REG_A_COEF, pick_coef());
        repeat (3 * 40 + 1) send_random_point();
        wait_idle();
        write_reg(REG_ROWS, 16'd3);
        finish_frame();
    endtask

    task automatic test_random_frames();
        int unsigned target, n;
        target = sent_count + RANDOM_ITEMS;
        while (sent_count < target) begin
            wait_idle();
            sender_gaps = ($urandom_range(0, 3) != 0);
            // widening is only safe at the start of a frame
            if (col_count == 0 && row_count == 0)
                write_reg(REG_COLUMNS, pick_size());
            else if ($urandom_range(0, 2) == 0)
                write_reg(REG_COLUMNS, 16'($urandom_range(0, clamp_size(columns_reg))));
            if ($urandom_range(0, 1) == 1) write_reg(REG_ROWS, pick_size());
            write_reg(REG_A_COEF, pick_coef());
            if ($urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 2 * clamp_size(columns_reg));
                repeat (n) send_random_point();
            end else begin
                send_random_point();
                finish_frame();
            end
        end
    endtask

    // receiver stall pattern: stalls, toggling and long ready stretches
    initial begin : ready_pattern
        int unsigned mode, run;
        forever begin
            mode = $urandom_range(0, 5);
            run  = (mode == 1) ? $urandom_range(50, 300) : $urandom_range(1, 16);
            repeat (run) begin
                @(posedge aclk);
                case (mode)
                    0: m_ready <= 1'b0;
                    2: m_ready <= ~m_ready;
                    default: m_ready <= 1'b1;
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_heights.size() == 0) begin
                $display("%0t: expected no transfer, got height %0d unstable %0b last %0b",
                         $time, m_new_height, m_unstable, m_last);
                mismatch_count++;
            end else begin
                head_result = pending_heights.pop_front();
                if (m_new_height !== head_result.new_height) begin
                    $display("%0t: new_height expected %0d, got %0d",
                             $time, head_result.new_height, m_new_height);
                    mismatch_count++;
                end
                if (m_unstable !== head_result.unstable) begin
                    $display("%0t: unstable expected %0b, got %0b",
                             $time, head_result.unstable, m_unstable);
                    mismatch_count++;
                end
                if (m_last !== head_result.last) begin
                    $display("%0t: last expected %0b, got %0b", $time, head_result.last, m_last);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_damping_edges();
        test_unstable_clamped();
        test_wide_columns();
        test_tall_rows();
        test_random_frames();
        wait_idle();
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
